[rtl/core/apmm_pkg.sv]
// ----------------------------------------------------------------------------
// apmm_pkg - shared types and constants for the peak min/max decimator
// Default widths, register indexes and the control bundles passed between
// the lanes, the merge stage and the top level.
// ----------------------------------------------------------------------------
package apmm_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int PEAK_SHIFT_DEF  = 8;
  localparam int PEAK_W          = 8;
  localparam int FRAME_W         = 16;
  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 1;

  localparam logic [FRAME_W-1:0] SPF_RESET = FRAME_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEREO_MODE       = 1'b0,
    REG_SAMPLES_PER_FRAME = 1'b1
  } cfg_reg_t;

  // per-lane tracker control
  typedef struct packed {
    logic upd;      // fold the sample into min/max
    logic restart;  // frame done: go back to restart values
  } lane_ctl_t;

  // merge stage control
  typedef struct packed {
    logic load;     // last word of a frame accepted
    logic stereo;   // right lane carries data
  } merge_ctl_t;

endpackage

[rtl/core/apmm_lane.sv]
// ----------------------------------------------------------------------------
// apmm_lane - one channel's running min/max tracker
// Folds accepted samples into the running extremes and presents the
// extremes including the current sample as shifted peak bytes.
// ----------------------------------------------------------------------------
module apmm_lane #(
  parameter int SAMPLE_BITS = apmm_pkg::SAMPLE_BITS_DEF,
  parameter int PEAK_SHIFT  = apmm_pkg::PEAK_SHIFT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  apmm_pkg::lane_ctl_t               ctl,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  output logic signed [apmm_pkg::PEAK_W-1:0] peak_max,
  output logic signed [apmm_pkg::PEAK_W-1:0] peak_min
);

  localparam int EXT_W = (SAMPLE_BITS > apmm_pkg::PEAK_W) ? SAMPLE_BITS : apmm_pkg::PEAK_W;
  localparam logic signed [SAMPLE_BITS-1:0] TOP = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] BOT = -TOP;

  logic signed [SAMPLE_BITS-1:0] run_max, run_min;
  logic signed [SAMPLE_BITS-1:0] run_max_next, run_min_next;
  logic signed [SAMPLE_BITS-1:0] max_sh, min_sh;
  logic signed [EXT_W-1:0]       max_ext, min_ext;

  always_comb begin
    run_max_next = run_max;
    run_min_next = run_min;
    if (ctl.upd) begin
      if (sample > run_max) run_max_next = sample;
      if (sample < run_min) run_min_next = sample;
    end
  end

  // floor shift, then sign-extend in case the shifted value is narrower than a byte
  assign max_sh   = run_max_next >>> PEAK_SHIFT;
  assign min_sh   = run_min_next >>> PEAK_SHIFT;
  assign max_ext  = EXT_W'(max_sh);
  assign min_ext  = EXT_W'(min_sh);
  assign peak_max = max_ext[apmm_pkg::PEAK_W-1:0];
  assign peak_min = min_ext[apmm_pkg::PEAK_W-1:0];

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      run_max <= BOT;
      run_min <= TOP;
    end else begin
      run_max <= run_max_next;
      run_min <= run_min_next;
    end
  end

endmodule

[rtl/core/apmm_merge.sv]
// ----------------------------------------------------------------------------
// apmm_merge - combines the lane peaks into one result word
// Holds the result in an output register until the receiver takes it;
// right fields are forced to zero in mono.
// ----------------------------------------------------------------------------
module apmm_merge (
  input  logic                               clk,
  input  logic                               rst,
  input  apmm_pkg::merge_ctl_t               ctl,
  input  logic signed [apmm_pkg::PEAK_W-1:0] left_max,
  input  logic signed [apmm_pkg::PEAK_W-1:0] left_min,
  input  logic signed [apmm_pkg::PEAK_W-1:0] right_max,
  input  logic signed [apmm_pkg::PEAK_W-1:0] right_min,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [apmm_pkg::PEAK_W-1:0] peak_max_left,
  output logic signed [apmm_pkg::PEAK_W-1:0] peak_min_left,
  output logic signed [apmm_pkg::PEAK_W-1:0] peak_max_right,
  output logic signed [apmm_pkg::PEAK_W-1:0] peak_min_right
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      peak_max_left  <= left_max;
      peak_min_left  <= left_min;
      peak_max_right <= ctl.stereo ? right_max : '0;
      peak_min_right <= ctl.stereo ? right_min : '0;
    end
  end

endmodule

[rtl/core/audio_peak_min_max_decimator.sv]
// ----------------------------------------------------------------------------
// audio_peak_min_max_decimator - waveform-overview min/max peak generator
//
// Input channel (in_valid/in_ready): one word per sample, sample_left only
// in mono, left/right pair in stereo. Output channel (out_valid/out_ready):
// one word per completed frame of samples_per_frame input words, carrying
// each channel's max and min shifted right by PEAK_SHIFT as signed bytes.
// Throughput is one input word per clock; the active channel lanes compare and
// update in the cycle the word is accepted. Latency: the result word is
// valid the cycle after the frame's last input word is accepted.
// When the receiver stalls, input words that do not close a frame are still
// taken; only the closing word waits until the output register is free.
// Config writes (cfg_write_en/cfg_index/cfg_data) take effect at once and
// do not restart the current frame; a frame length of 0 acts as 1.
// Reset: stereo_mode=0, samples_per_frame=256, trackers at their restart
// values, frame count zero, output empty.
// ----------------------------------------------------------------------------
module audio_peak_min_max_decimator #(
  parameter int SAMPLE_BITS = apmm_pkg::SAMPLE_BITS_DEF,
  parameter int PEAK_SHIFT  = apmm_pkg::PEAK_SHIFT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write_en,
  input  logic [apmm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [apmm_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [SAMPLE_BITS-1:0]         sample_left,
  input  logic signed [SAMPLE_BITS-1:0]         sample_right,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [apmm_pkg::PEAK_W-1:0]    peak_max_left,
  output logic signed [apmm_pkg::PEAK_W-1:0]    peak_min_left,
  output logic signed [apmm_pkg::PEAK_W-1:0]    peak_max_right,
  output logic signed [apmm_pkg::PEAK_W-1:0]    peak_min_right
);

  logic                                stereo_mode;
  logic [apmm_pkg::FRAME_W-1:0]        samples_per_frame;
  logic [apmm_pkg::FRAME_W-1:0]        items_in_frame;
  logic [apmm_pkg::FRAME_W:0]          count_inc;
  logic [apmm_pkg::FRAME_W-1:0]        target;
  logic                                frame_last;
  logic                                accept;
  apmm_pkg::lane_ctl_t                 ctl_left, ctl_right;
  apmm_pkg::merge_ctl_t                ctl_merge;
  logic signed [apmm_pkg::PEAK_W-1:0]  l_max, l_min, r_max, r_min;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stereo_mode       <= 1'b0;
      samples_per_frame <= apmm_pkg::SPF_RESET;
    end else if (cfg_write_en) begin
      case (apmm_pkg::cfg_reg_t'(cfg_index))
        apmm_pkg::REG_STEREO_MODE:       stereo_mode       <= cfg_data[0];
        apmm_pkg::REG_SAMPLES_PER_FRAME: samples_per_frame <= cfg_data[apmm_pkg::FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  assign target     = (samples_per_frame == '0) ? apmm_pkg::FRAME_W'(1) : samples_per_frame;
  assign count_inc  = {1'b0, items_in_frame} + (apmm_pkg::FRAME_W+1)'(1);
  // >= covers a frame length lowered mid-frame
  assign frame_last = count_inc >= {1'b0, target};
  assign in_ready   = !frame_last || !out_valid || out_ready;
  assign accept     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      items_in_frame <= '0;
    end else if (accept) begin
      items_in_frame <= frame_last ? '0 : count_inc[apmm_pkg::FRAME_W-1:0];
    end
  end

  assign ctl_left.upd      = accept;
  assign ctl_left.restart  = accept && frame_last;
  assign ctl_right.upd     = accept && stereo_mode;
  assign ctl_right.restart = accept && frame_last;
  assign ctl_merge.load    = accept && frame_last;
  assign ctl_merge.stereo  = stereo_mode;

  apmm_lane #(.SAMPLE_BITS(SAMPLE_BITS), .PEAK_SHIFT(PEAK_SHIFT)) u_lane_left (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl_left),
    .sample   (sample_left),
    .peak_max (l_max),
    .peak_min (l_min)
  );

  apmm_lane #(.SAMPLE_BITS(SAMPLE_BITS), .PEAK_SHIFT(PEAK_SHIFT)) u_lane_right (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl_right),
    .sample   (sample_right),
    .peak_max (r_max),
    .peak_min (r_min)
  );

  apmm_merge u_merge (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl_merge),
    .left_max       (l_max),
    .left_min       (l_min),
    .right_max      (r_max),
    .right_min      (r_min),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .peak_max_left  (peak_max_left),
    .peak_min_left  (peak_min_left),
    .peak_max_right (peak_max_right),
    .peak_min_right (peak_min_right)
  );

  // a frame-closing word never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    accept && frame_last |-> !out_valid || out_ready)
    else $error("result overwritten while stalled");

  // a frame-closing word always produces a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept && frame_last |=> out_valid)
    else $error("frame closed without a result");

  // count restarts after the frame-closing word
  a_count_restart: assert property (@(posedge clk) disable iff (rst)
    accept && frame_last |=> items_in_frame == '0)
    else $error("frame count not restarted");

  // reset leaves the block empty
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && items_in_frame == '0)
    else $error("state not cleared by reset");

endmodule

[dv/tb_audio_peak_min_max_decimator.sv]
// ----------------------------------------------------------------------------
// tb_audio_peak_min_max_decimator - self-checking bench for the peak decimator
// Drives PCM words with random gaps against a randomly stalling receiver and
// checks every peak word against its typed table entry or else a cycle-free
// model of the min/max trackers. A directed table covers sample extremes,
// both modes, zero and maximum frame lengths and mid-frame register changes.
// Random phases with varied settings follow.
// ----------------------------------------------------------------------------
module tb_audio_peak_min_max_decimator;
  import apmm_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int PS = PEAK_SHIFT_DEF;
  localparam logic signed [SB-1:0] TRK_TOP = SB'((2 ** (SB - 1)) - 1);
  localparam int RANDOM_WORDS = 550;

  typedef struct packed {
    logic signed [PEAK_W-1:0] max_l;
    logic signed [PEAK_W-1:0] min_l;
    logic signed [PEAK_W-1:0] max_r;
    logic signed [PEAK_W-1:0] min_r;
  } peak_word_t;

  typedef struct {
    logic             is_write;
    cfg_reg_t         idx;
    logic [CFG_W-1:0] data;
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
    logic             has_want;
    peak_word_t       want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SB-1:0] sample_left = '0;
  logic signed [SB-1:0] sample_right = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [PEAK_W-1:0] peak_max_left;
  logic signed [PEAK_W-1:0] peak_min_left;
  logic signed [PEAK_W-1:0] peak_max_right;
  logic signed [PEAK_W-1:0] peak_min_right;

  // typed expectation riding along with the input word
  logic word_typed = 1'b0;
  peak_word_t word_want = '0;
  logic throttle = 1'b1;

  // model state
  logic stereo_on;
  logic [FRAME_W-1:0] frame_len;
  logic [FRAME_W-1:0] frame_count;
  logic signed [SB-1:0] trk_min [2];
  logic signed [SB-1:0] trk_max [2];

  peak_word_t peaks_due[$];
  plan_row_t plan[$];
  int mismatches = 0;

  audio_peak_min_max_decimator dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample_left(sample_left),
    .sample_right(sample_right),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .peak_max_left(peak_max_left),
    .peak_min_left(peak_min_left),
    .peak_max_right(peak_max_right),
    .peak_min_right(peak_min_right)
  );

  always #1 clk = ~clk;

  initial begin
    #200000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic signed [PEAK_W-1:0] peak_of(input logic signed [SB-1:0] v);
    logic signed [SB-1:0] s;
    s = v >>> PS;
    return s[PEAK_W-1:0];
  endfunction

  task automatic restart_tracks();
    for (int c = 0; c < 2; c++) begin
      trk_min[c] = TRK_TOP;
      trk_max[c] = -TRK_TOP;
    end
    frame_count = '0;
  endtask

  task automatic fold_sample(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r,
                             output logic emit, output peak_word_t w);
    logic [FRAME_W:0] cnt;
    logic [FRAME_W:0] goal;
    goal = (frame_len == '0) ? (FRAME_W+1)'(1) : {1'b0, frame_len};
    if (l < trk_min[0]) trk_min[0] = l;
    if (l > trk_max[0]) trk_max[0] = l;
    if (stereo_on) begin
      if (r < trk_min[1]) trk_min[1] = r;
      if (r > trk_max[1]) trk_max[1] = r;
    end
    cnt = {1'b0, frame_count} + (FRAME_W+1)'(1);
    w = '0;
    emit = (cnt >= goal);
    if (!emit) begin
      frame_count = cnt[FRAME_W-1:0];
    end else begin
      w.max_l = peak_of(trk_max[0]);
      w.min_l = peak_of(trk_min[0]);
      if (stereo_on) begin
        w.max_r = peak_of(trk_max[1]);
        w.min_r = peak_of(trk_min[1]);
      end
      restart_tracks();
    end
  endtask

  // check results, then fold in any input word taken at this edge
  always @(posedge clk) begin
    peak_word_t got;
    peak_word_t want;
    peak_word_t calc;
    logic emit;
    if (!rst && out_valid && out_ready) begin
      got = {peak_max_left, peak_min_left, peak_max_right, peak_min_right};
      if (peaks_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected peak word, got max_l %0d min_l %0d max_r %0d min_r %0d",
                 $time, got.max_l, got.min_l, got.max_r, got.min_r);
      end else begin
        want = peaks_due.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: peak mismatch, expected max_l %0d min_l %0d max_r %0d min_r %0d",
                   $time, want.max_l, want.min_l, want.max_r, want.min_r);
          $display("%0t:                got      max_l %0d min_l %0d max_r %0d min_r %0d",
                   $time, got.max_l, got.min_l, got.max_r, got.min_r);
        end
      end
    end
    if (!rst && in_valid && in_ready) begin
      fold_sample(sample_left, sample_right, emit, calc);
      if (emit) peaks_due.push_back(word_typed ? word_want : calc);
    end
    out_ready <= !throttle || ($urandom_range(99) >= 37);
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    // let the checker fold the last word before looking at what is pending
    @(posedge clk);
    while (peaks_due.size() != 0 || out_valid) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (idx == REG_STEREO_MODE) stereo_on = val[0];
    else frame_len = val[FRAME_W-1:0];
  endtask

  task automatic send_word(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r,
                           input logic typed, input peak_word_t want);
    while (throttle && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_left <= l;
    sample_right <= r;
    word_typed <= typed;
    word_want <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic add_write(input cfg_reg_t idx, input int val);
    plan_row_t row;
    row = '{idx: REG_STEREO_MODE, default: '0};
    row.is_write = 1'b1;
    row.idx = idx;
    row.data = val[CFG_W-1:0];
    plan.push_back(row);
  endtask

  task automatic add_word(input int l, input int r, input logic typed,
                          input int a = 0, input int b = 0, input int c = 0, input int d = 0);
    plan_row_t row;
    row = '{idx: REG_STEREO_MODE, default: '0};
    row.left = l[SB-1:0];
    row.right = r[SB-1:0];
    row.has_want = typed;
    row.want = {a[PEAK_W-1:0], b[PEAK_W-1:0], c[PEAK_W-1:0], d[PEAK_W-1:0]};
    plan.push_back(row);
  endtask

  function automatic logic signed [SB-1:0] pick_sample();
    case ($urandom_range(9))
      0: return TRK_TOP;
      1: return {1'b1, {(SB - 1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return SB'($urandom);
    endcase
  endfunction

  initial begin
    logic [CFG_W-1:0] spf;
    int n;
    int sent;
    int phase;
    stereo_on = 1'b0;
    frame_len = SPF_RESET;
    restart_tracks();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // mono, one word per frame: extremes and rounding toward minus infinity
    add_write(REG_SAMPLES_PER_FRAME, 1);
    add_word(32767, 0, 1, 127, 127, 0, 0);
    add_word(-32768, 0, 1, -128, -128, 0, 0);
    add_word(0, -32768, 1, 0, 0, 0, 0);       // right ignored in mono
    add_word(-1, 32767, 1, -1, -1, 0, 0);
    add_word(255, 0, 1, 0, 0, 0, 0);
    add_word(256, 0, 1, 1, 1, 0, 0);
    add_word(-257, 0, 1, -2, -2, 0, 0);
    add_write(REG_STEREO_MODE, 1);
    add_word(-32768, 32767, 1, -128, -128, 127, 127);
    add_word(32767, -32768, 1, 127, 127, -128, -128);
    add_word(23130, -11213, 0);
    // zero frame length behaves as one
    add_write(REG_SAMPLES_PER_FRAME, 0);
    add_word(4660, -4660, 0);
    add_word(-1, -1, 1, -1, -1, -1, -1);
    // mode dropped to mono with stereo words already in the frame
    add_write(REG_SAMPLES_PER_FRAME, 4);
    add_word(1000, -20000, 0);
    add_word(-30000, 12345, 0);
    add_word(512, 700, 0);
    add_write(REG_STEREO_MODE, 0);
    add_word(-7, 31000, 0);
    // longest frame, then shortened below the running count
    add_write(REG_SAMPLES_PER_FRAME, 16'hFFFF);
    add_word(-12000, 0, 0);
    add_word(9000, 0, 0);
    add_word(300, 0, 0);
    add_write(REG_SAMPLES_PER_FRAME, 2);
    add_word(-5, 0, 0);

    foreach (plan[i]) begin
      if (plan[i].is_write) write_reg(plan[i].idx, plan[i].data);
      else send_word(plan[i].left, plan[i].right, plan[i].has_want, plan[i].want);
    end

    sent = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      throttle <= !(phase >= 8 && phase < 14) && (phase % 6 != 4);
      case ($urandom_range(99)) inside
        [0:7]:   spf = '0;
        [8:13]:  spf = 16'hFFFF;
        [14:19]: spf = CFG_W'($urandom_range(60, 17));
        default: spf = CFG_W'($urandom_range(12, 1));
      endcase
      case ($urandom_range(2))
        0: write_reg(REG_STEREO_MODE, CFG_W'($urandom_range(1)));
        1: write_reg(REG_SAMPLES_PER_FRAME, spf);
        default: begin
          write_reg(REG_STEREO_MODE, CFG_W'($urandom_range(1)));
          write_reg(REG_SAMPLES_PER_FRAME, spf);
        end
      endcase
      n = (frame_len == 16'hFFFF) ? $urandom_range(8, 2) : $urandom_range(30, 5);
      repeat (n) begin
        send_word(pick_sample(), pick_sample(), 1'b0, '0);
        sent++;
      end
      phase++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (peaks_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && peaks_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/apmm_pkg.sv
rtl/core/apmm_lane.sv
rtl/core/apmm_merge.sv
rtl/core/audio_peak_min_max_decimator.sv
dv/tb_audio_peak_min_max_decimator.sv
